/* hw/rtl/sbb_pkg.sv */
// shared types, constants and rounding helpers of the separable binomial blur
// no dependencies
package sbb_pkg;

  localparam int MAX_ROW_BYTES_DEF = 4096;
  localparam int ROW_W             = 13;
  localparam int QUEUE_DEPTH       = 4;
  localparam int FILL_DEPTH        = 4;

  // configuration register indexes
  localparam logic [1:0] REG_ROW_BYTES   = 2'd0;
  localparam logic [1:0] REG_ROW_TOTAL   = 2'd1;
  localparam logic [1:0] REG_LAYOUT_MODE = 2'd2;

  // layout codes
  localparam logic [1:0] LAYOUT_PACKED    = 2'd1;
  localparam logic [1:0] LAYOUT_LUMA_ONLY = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       row_end;
    logic       frame_end;
  } out_word_t;

  typedef enum logic [1:0] {
    OP_FILL,
    OP_HORIZ,
    OP_FLUSH
  } op_t;

  typedef enum logic [1:0] {
    DIST_1,
    DIST_2,
    DIST_4
  } dist_t;

  // one command from the front to the back
  typedef struct packed {
    op_t        op;
    logic [7:0] pix;
    dist_t      dsel;
    logic       has_l;
    logic       has_r;
    logic       pass;
    logic       first_row;
    logic       two_tap;
    logic       single_row;
    logic       row_end;
    logic       frame_end;
    logic       restart;
  } cmd_t;

  function automatic logic [7:0] pair(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + 9'd1;
    return s[8:1];
  endfunction

  function automatic logic [7:0] triple(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
    logic [9:0] s;
    s = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c} + 10'd2;
    return s[9:2];
  endfunction

endpackage

/* hw/rtl/sbb_front.sv */
// front end: configuration registers, stream position tracking, command issue
// depends on sbb_pkg
module sbb_front #(
  parameter int MAX_ROW_BYTES = sbb_pkg::MAX_ROW_BYTES_DEF,
  parameter int AW            = $clog2(MAX_ROW_BYTES)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  sbb_pkg::in_word_t      in_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [sbb_pkg::ROW_W-1:0] cfg_data,
  output logic                   push,
  output sbb_pkg::cmd_t          cmd,
  output logic [AW-1:0]          cmd_col,
  output logic                   win_clear
);

  localparam int CW = $clog2(MAX_ROW_BYTES + 1);
  localparam int RW = sbb_pkg::ROW_W;

  logic [RW-1:0] row_bytes_r, row_bytes_nxt;
  logic [RW-1:0] row_total_r, row_total_nxt;
  logic [1:0]    layout_r, layout_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] hc_col_r, hc_col_nxt;
  logic [RW-1:0] hc_row_r, hc_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [2:0]    fill_r, fill_nxt;

  logic [CW-1:0] w;
  logic [RW-1:0] r;
  logic          accept, cfg_wr;
  logic          pix_ok, drain_shift, drain_flush, do_shift, filling, compute;
  logic          flush_last;
  logic [2:0]    dval;
  logic [CW:0]   reach;
  logic [CW-1:0] hc_col_inc, in_col_inc, out_col_inc;

  // effective geometry
  always_comb begin
    if (row_bytes_r == '0) begin
      w = CW'(1);
    end else if (32'(row_bytes_r) > MAX_ROW_BYTES) begin
      w = CW'(MAX_ROW_BYTES);
    end else begin
      w = CW'(row_bytes_r);
    end
    r = (row_total_r == '0) ? RW'(1) : row_total_r;
  end

  // classify the item
  assign accept      = in_valid && !in_stall;
  assign cfg_wr      = cfg_valid && cfg_ready && (cfg_index == sbb_pkg::REG_ROW_BYTES ||
                       cfg_index == sbb_pkg::REG_ROW_TOTAL ||
                       cfg_index == sbb_pkg::REG_LAYOUT_MODE);
  assign pix_ok      = !in_data.kind && (in_row_r < r);
  assign drain_shift = in_data.kind && (in_row_r >= r) && (hc_row_r < r);
  assign drain_flush = in_data.kind && (in_row_r >= r) && (hc_row_r >= r) && (out_col_r < w);
  assign do_shift    = pix_ok || drain_shift;
  assign filling     = fill_r != 3'(sbb_pkg::FILL_DEPTH);
  assign compute     = do_shift && !filling && (hc_row_r < r);
  assign flush_last  = out_col_r == (w - CW'(1));
  assign hc_col_inc  = hc_col_r + CW'(1);
  assign in_col_inc  = in_col_r + CW'(1);
  assign out_col_inc = out_col_r + CW'(1);
  assign win_clear   = cfg_wr;

  // neighbour distance and edge flags for the horizontal stage, and the fill, horizontal or flush command
  always_comb begin
    cmd = '0;
    cmd_col = '0;
    cmd.pix = in_data.kind ? 8'd0 : in_data.pixel_in;
    if (layout_r == sbb_pkg::LAYOUT_PACKED) begin
      cmd.dsel = hc_col_r[0] ? sbb_pkg::DIST_4 : sbb_pkg::DIST_2;
      dval     = hc_col_r[0] ? 3'd4 : 3'd2;
    end else if (layout_r == sbb_pkg::LAYOUT_LUMA_ONLY) begin
      cmd.dsel = sbb_pkg::DIST_2;
      dval     = 3'd2;
    end else begin
      cmd.dsel = sbb_pkg::DIST_1;
      dval     = 3'd1;
    end
    reach = {1'b0, hc_col_r} + (CW+1)'(dval);
    if (drain_flush) begin
      cmd.op         = sbb_pkg::OP_FLUSH;
      cmd_col        = out_col_r[AW-1:0];
      cmd.pass       = (layout_r == sbb_pkg::LAYOUT_LUMA_ONLY) && out_col_r[0];
      cmd.single_row = r < RW'(2);
      cmd.row_end    = flush_last;
      cmd.frame_end  = flush_last;
      cmd.restart    = flush_last;
    end else if (compute) begin
      cmd.op        = sbb_pkg::OP_HORIZ;
      cmd_col       = hc_col_r[AW-1:0];
      cmd.has_l     = hc_col_r >= CW'(dval);
      cmd.has_r     = reach < {1'b0, w};
      cmd.pass      = (layout_r == sbb_pkg::LAYOUT_LUMA_ONLY) && hc_col_r[0];
      cmd.first_row = hc_row_r == '0;
      cmd.two_tap   = hc_row_r == RW'(1);
      cmd.row_end   = hc_col_r == (w - CW'(1));
    end else begin
      cmd.op = sbb_pkg::OP_FILL;
    end
  end

  assign push = accept && !cfg_wr && (do_shift || drain_flush);

  // configuration writes and position update
  always_comb begin
    row_bytes_nxt = row_bytes_r;
    row_total_nxt = row_total_r;
    layout_nxt    = layout_r;
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    hc_col_nxt    = hc_col_r;
    hc_row_nxt    = hc_row_r;
    out_col_nxt   = out_col_r;
    fill_nxt      = fill_r;
    if (cfg_wr) begin
      unique case (cfg_index)
        sbb_pkg::REG_ROW_BYTES: row_bytes_nxt = cfg_data;
        sbb_pkg::REG_ROW_TOTAL: row_total_nxt = cfg_data;
        default:                layout_nxt    = cfg_data[1:0];
      endcase
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      hc_col_nxt  = '0;
      hc_row_nxt  = '0;
      out_col_nxt = '0;
      fill_nxt    = '0;
    end else if (accept) begin
      if (pix_ok) begin
        if (in_col_inc >= w) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + RW'(1);
        end else begin
          in_col_nxt = in_col_inc;
        end
      end
      if (do_shift && filling) begin
        fill_nxt = fill_r + 3'd1;
      end
      if (compute) begin
        if (hc_row_r != '0) begin
          out_col_nxt = (hc_col_inc >= w) ? '0 : hc_col_inc;
        end
        if (hc_col_inc >= w) begin
          hc_col_nxt = '0;
          hc_row_nxt = hc_row_r + RW'(1);
        end else begin
          hc_col_nxt = hc_col_inc;
        end
      end
      if (drain_flush) begin
        out_col_nxt = out_col_inc;
        if (flush_last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          hc_col_nxt  = '0;
          hc_row_nxt  = '0;
          out_col_nxt = '0;
          fill_nxt    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= RW'(720);
      row_total_r <= RW'(480);
      layout_r    <= '0;
      in_col_r    <= '0;
      in_row_r    <= '0;
      hc_col_r    <= '0;
      hc_row_r    <= '0;
      out_col_r   <= '0;
      fill_r      <= '0;
    end else begin
      row_bytes_r <= row_bytes_nxt;
      row_total_r <= row_total_nxt;
      layout_r    <= layout_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      hc_col_r    <= hc_col_nxt;
      hc_row_r    <= hc_row_nxt;
      out_col_r   <= out_col_nxt;
      fill_r      <= fill_nxt;
    end
  end

  // horizontal stage never runs ahead of the raw input
  a_hc_behind: assert property (@(posedge clk) disable iff (!rst_n) hc_row_r <= in_row_r)
    else $error("horizontal stage ahead of input");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 3'(sbb_pkg::FILL_DEPTH))
    else $error("fill count overrun");
  a_hc_col: assert property (@(posedge clk) disable iff (!rst_n) hc_col_r < w)
    else $error("horizontal column out of row");
  a_out_col: assert property (@(posedge clk) disable iff (!rst_n) out_col_r < w)
    else $error("output column out of row");
  a_push: assert property (@(posedge clk) disable iff (!rst_n) push |-> !in_stall)
    else $error("push into full queue");

endmodule

/* hw/rtl/sbb_queue.sv */
// short command queue between front and back
// depends on sbb_pkg
module sbb_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic          q_valid,
  output logic [DW-1:0] q_data,
  output logic          full
);

  localparam int DEPTH = sbb_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  logic [DW-1:0] slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = count_r == (PW+1)'(DEPTH);
  assign q_valid = count_r != '0;
  assign q_data  = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/sbb_back.sv */
// back end: byte window, horizontal filter, line stores, vertical filter, output word
// depends on sbb_pkg
module sbb_back #(
  parameter int MAX_ROW_BYTES = sbb_pkg::MAX_ROW_BYTES_DEF,
  parameter int AW            = $clog2(MAX_ROW_BYTES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  sbb_pkg::cmd_t      q_cmd,
  input  logic [AW-1:0]      q_col,
  output logic               pop,
  input  logic               win_clear,
  output logic               out_valid,
  input  logic               out_stall,
  output sbb_pkg::out_word_t out_data
);

  logic [7:0] win_r [8];
  logic [7:0] mem_curr [MAX_ROW_BYTES];
  logic [7:0] mem_prev [MAX_ROW_BYTES];

  logic               en, fwd, a_write, a_emit;
  logic [7:0]         lft, rgt, ctr, h;
  logic [7:0]         v;
  logic               a_valid_r;
  sbb_pkg::cmd_t      a_cmd_r;
  logic [AW-1:0]      a_col_r;
  logic [7:0]         a_h_r, a_cur_r, a_prev_r;
  logic               out_valid_r;
  sbb_pkg::out_word_t out_word_r;

  assign en  = !out_valid_r || !out_stall;
  assign pop = en && q_valid;

  // horizontal taps around the byte four places behind the newest
  always_comb begin
    ctr = win_r[3];
    unique case (q_cmd.dsel)
      sbb_pkg::DIST_1: begin
        lft = win_r[4];
        rgt = win_r[2];
      end
      sbb_pkg::DIST_2: begin
        lft = win_r[5];
        rgt = win_r[1];
      end
      sbb_pkg::DIST_4: begin
        lft = win_r[7];
        rgt = q_cmd.pix;
      end
      default: begin
        lft = win_r[4];
        rgt = win_r[2];
      end
    endcase
    if (q_cmd.pass) begin
      h = ctr;
    end else if (q_cmd.has_l && q_cmd.has_r) begin
      h = sbb_pkg::triple(lft, ctr, rgt);
    end else if (q_cmd.has_l) begin
      h = sbb_pkg::pair(lft, ctr);
    end else if (q_cmd.has_r) begin
      h = sbb_pkg::pair(ctr, rgt);
    end else begin
      h = ctr;
    end
  end

  // window shift register
  always_ff @(posedge clk) begin
    if (!rst_n || win_clear) begin
      for (int i = 0; i < 8; i++) begin
        win_r[i] <= '0;
      end
    end else if (pop && q_cmd.op != sbb_pkg::OP_FLUSH) begin
      win_r[0] <= q_cmd.pix;
      for (int i = 1; i < 8; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end else if (pop && q_cmd.restart) begin
      for (int i = 0; i < 8; i++) begin
        win_r[i] <= '0;
      end
    end
  end

  // stage a: line store read with bypass of the write in flight
  assign a_write = en && a_valid_r && (a_cmd_r.op == sbb_pkg::OP_HORIZ);
  assign fwd     = a_write && (a_col_r == q_col);

  always_ff @(posedge clk) begin
    if (en) begin
      a_cmd_r <= q_cmd;
      a_col_r <= q_col;
      a_h_r   <= h;
      if (fwd) begin
        a_cur_r  <= a_h_r;
        a_prev_r <= a_cur_r;
      end else begin
        a_cur_r  <= mem_curr[q_col];
        a_prev_r <= mem_prev[q_col];
      end
    end
    if (a_write) begin
      mem_prev[a_col_r] <= a_cur_r;
      mem_curr[a_col_r] <= a_h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= pop;
    end
  end

  // vertical filter
  always_comb begin
    if (a_cmd_r.op == sbb_pkg::OP_FLUSH) begin
      v = (a_cmd_r.pass || a_cmd_r.single_row) ? a_cur_r : sbb_pkg::pair(a_prev_r, a_cur_r);
    end else if (a_cmd_r.pass) begin
      v = a_cur_r;
    end else if (a_cmd_r.two_tap) begin
      v = sbb_pkg::pair(a_cur_r, a_h_r);
    end else begin
      v = sbb_pkg::triple(a_prev_r, a_cur_r, a_h_r);
    end
  end

  assign a_emit = a_valid_r && ((a_cmd_r.op == sbb_pkg::OP_FLUSH) ||
                  (a_cmd_r.op == sbb_pkg::OP_HORIZ && !a_cmd_r.first_row));

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= a_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r.pixel_out <= v;
      out_word_r.row_end   <= a_cmd_r.row_end;
      out_word_r.frame_end <= a_cmd_r.frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

/* hw/rtl/separable_binomial_blur_top.sv */
// an item that yields a word passes the command queue, stage a and the output word register
// throughput: one word per cycle while out_stall is low; the line-store bypass keeps back-to-back columns going
// output row n is produced while row n+1 streams in, the last row by drain words
// reset: synchronous active-low rst_n clears positions, window, queue and output valid
// line stores hold no reset value; every entry is written before it is read in a frame
// top level: front end, command queue, back end
module separable_binomial_blur_top #(
  parameter int MAX_ROW_BYTES = sbb_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  sbb_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output sbb_pkg::out_word_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [sbb_pkg::ROW_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_ROW_BYTES);
  localparam int DW = $bits(sbb_pkg::cmd_t) + AW;

  logic          push, pop, q_valid, q_full, win_clear;
  sbb_pkg::cmd_t f_cmd, q_cmd;
  logic [AW-1:0] f_col, q_col;
  logic [DW-1:0] q_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  sbb_front #(.MAX_ROW_BYTES(MAX_ROW_BYTES), .AW(AW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (q_full),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .cmd       (f_cmd),
    .cmd_col   (f_col),
    .win_clear (win_clear)
  );

  sbb_queue #(.DW(DW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_cmd, f_col}),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .full      (q_full)
  );

  assign q_cmd = q_data[DW-1:AW];
  assign q_col = q_data[AW-1:0];

  sbb_back #(.MAX_ROW_BYTES(MAX_ROW_BYTES), .AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_col     (q_col),
    .pop       (pop),
    .win_clear (win_clear),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* sim/tb.sv */
// testbench of separable_binomial_blur_top: random and directed frames checked against
// a cycle-free predictor of the 3x3 binomial blur held in a small scoreboard class
// depends on sbb_pkg and the rtl of the block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = 4096;
  localparam int QUIET_LIMIT = 20000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // predictor state and expected word store
  class blur_board;
    int unsigned rbytes, rtotal, layout;
    logic [7:0] win[9];
    logic [7:0] lprev[MAXW];
    logic [7:0] lcurr[MAXW];
    int unsigned icol, irow, ocol, orow, fill, hcol, hrow;
    sbb_pkg::out_word_t pending[$];
    int errors;

    function void restart();
      for (int i = 0; i < 9; i++) win[i] = 8'd0;
      icol = 0; irow = 0; ocol = 0; orow = 0; fill = 0; hcol = 0; hrow = 0;
    endfunction

    function void init();
      rbytes = 720; rtotal = 480; layout = 0; errors = 0;
      for (int i = 0; i < MAXW; i++) begin
        lprev[i] = 8'd0; lcurr[i] = 8'd0;
      end
      restart();
    endfunction

    function int unsigned eff_w();
      if (rbytes == 0) return 1;
      if (rbytes > MAXW) return MAXW;
      return rbytes;
    endfunction

    function int unsigned eff_r();
      return (rtotal == 0) ? 1 : rtotal;
    endfunction

    function bit chroma(int unsigned c);
      return layout == sbb_pkg::LAYOUT_LUMA_ONLY && c[0];
    endfunction

    function logic [7:0] avg2(int unsigned a, int unsigned b);
      return 8'((a + b + 1) >> 1);
    endfunction

    function logic [7:0] avg3(int unsigned a, int unsigned b, int unsigned c);
      return 8'((a + 2 * b + c + 2) >> 2);
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] val);
      if (idx == sbb_pkg::REG_ROW_BYTES) rbytes = 32'(val);
      else if (idx == sbb_pkg::REG_ROW_TOTAL) rtotal = 32'(val);
      else if (idx == sbb_pkg::REG_LAYOUT_MODE) layout = 32'(val[1:0]);
      else return;
      restart();
    endfunction

    function logic [7:0] horiz(int unsigned c, int unsigned w);
      int unsigned d;
      bit hl, hr;
      if (chroma(c)) return win[4];
      if (layout == sbb_pkg::LAYOUT_PACKED) d = c[0] ? 4 : 2;
      else if (layout == sbb_pkg::LAYOUT_LUMA_ONLY) d = 2;
      else d = 1;
      hl = c >= d;
      hr = c + d < w;
      if (hl && hr) return avg3(win[4 + d], win[4], win[4 - d]);
      if (hl) return avg2(win[4 + d], win[4]);
      if (hr) return avg2(win[4], win[4 - d]);
      return win[4];
    endfunction

    function void push(logic [7:0] v, int unsigned c, int unsigned w, bit last);
      sbb_pkg::out_word_t o;
      o.pixel_out = v;
      o.row_end = (c == w - 1);
      o.frame_end = last;
      pending.push_back(o);
    endfunction

    function void shift(logic [7:0] b);
      int unsigned w, r, c;
      logic [7:0] h, v, cur;
      w = eff_w(); r = eff_r();
      for (int i = 8; i > 0; i--) win[i] = win[i - 1];
      win[0] = b;
      if (fill < 4) begin
        fill++;
        return;
      end
      if (hrow >= r) return;
      c = hcol;
      h = horiz(c, w);
      if (hrow == 0) begin
        lcurr[c] = h;
      end else begin
        cur = lcurr[c];
        if (chroma(c)) v = cur;
        else if (hrow >= 2) v = avg3(lprev[c], cur, h);
        else v = avg2(cur, h);
        push(v, c, w, 0);
        lprev[c] = cur;
        lcurr[c] = h;
        orow = hrow - 1;
        ocol = c + 1;
        if (ocol >= w) begin
          ocol = 0; orow++;
        end
      end
      hcol++;
      if (hcol >= w) begin
        hcol = 0; hrow++;
      end
    endfunction

    // note an accepted input word
    function void note_input(sbb_pkg::in_word_t x);
      int unsigned w, r, c;
      logic [7:0] v;
      bit last;
      w = eff_w(); r = eff_r();
      if (!x.kind) begin
        if (irow >= r) return;
        icol++;
        if (icol >= w) begin
          icol = 0; irow++;
        end
        shift(x.pixel_in);
        return;
      end
      if (irow < r) return;
      if (hrow < r) begin
        shift(8'd0);
        return;
      end
      c = ocol;
      if (c >= w) return;
      if (chroma(c) || r < 2) v = lcurr[c];
      else v = avg2(lprev[c], lcurr[c]);
      last = (c == w - 1);
      push(v, c, w, last);
      ocol = c + 1;
      if (last) restart();
    endfunction

    // compare one accepted result word
    function void check_output(sbb_pkg::out_word_t got);
      sbb_pkg::out_word_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.pixel_out !== got.pixel_out)
        $display("%0t: pixel_out expected %0d actual %0d", $time, e.pixel_out, got.pixel_out);
      if (e.row_end !== got.row_end)
        $display("%0t: row_end expected %0d actual %0d", $time, e.row_end, got.row_end);
      if (e.frame_end !== got.frame_end)
        $display("%0t: frame_end expected %0d actual %0d", $time, e.frame_end, got.frame_end);
      if (e !== got) errors++;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, cfg_valid, cfg_ready;
  logic out_stall = 1'b0;
  sbb_pkg::in_word_t in_data;
  sbb_pkg::out_word_t out_data;
  logic [1:0] cfg_index;
  logic [12:0] cfg_data;

  blur_board board;
  int send_idle_pct, recv_idle_pct;
  int hold_cycles = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int quiet = 0;
  int sent;

  separable_binomial_blur_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stall, with long hold-offs on request
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_ack != hold_req) begin
      out_stall <= 1'b1;
      hold_ack <= hold_req;
      hold_cycles <= 59;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_output(out_data);
    if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall) ||
                  (cfg_valid && cfg_ready)))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > QUIET_LIMIT) begin
      $display("** separable_binomial_blur_top: FAILED **");
      $finish;
    end
  end

  // send one word, with random idling before it; valid stays up until the next idle
  task automatic send_word(logic k, logic [7:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{kind: k, pixel_in: p};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input('{kind: k, pixel_in: p});
    sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // valid stays up after the write; the caller drops it
  task automatic write_cfg(logic [1:0] idx, logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, val);
  endtask

  task automatic set_geometry(int w, int r, int m);
    write_cfg(sbb_pkg::REG_ROW_BYTES, 13'(w));
    write_cfg(sbb_pkg::REG_ROW_TOTAL, 13'(r));
    write_cfg(sbb_pkg::REG_LAYOUT_MODE, 13'(m));
    cfg_valid <= 1'b0;
  endtask

  // one frame of pixels, random noise words mixed in when noisy, then drains
  task automatic run_frame(int w, int r, bit noisy, bit extreme);
    for (int i = 0; i < w * r; i++) begin
      if (noisy && $urandom_range(19) == 0) send_word(1'b1, 8'($urandom));
      if (extreme) send_word(1'b0, (i % 3 == 0) ? 8'hff : (i % 3 == 1) ? 8'h00 : 8'h55);
      else send_word(1'b0, 8'($urandom));
    end
    if (noisy && $urandom_range(3) == 0) send_word(1'b0, 8'($urandom));
    for (int i = 0; i < w + 6; i++) send_word(1'b1, 8'($urandom));
  endtask

  initial begin
    int w, r, m;
    board = new();
    board.init();
    rst_n = 0; in_valid = 0; in_data = '0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    send_idle_pct = 0; recv_idle_pct = 0; sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every layout, single row, zero geometry, layout three
    set_geometry(4, 2, 0);
    run_frame(4, 2, 0, 1);
    wait_idle();
    set_geometry(8, 1, 1);
    run_frame(8, 1, 0, 1);
    wait_idle();
    set_geometry(0, 0, 3);
    run_frame(1, 1, 0, 0);
    wait_idle();
    set_geometry(8, 2, 2);
    send_word(1'b1, 8'hff);
    run_frame(8, 2, 0, 1);
    send_word(1'b1, 8'h00);
    wait_idle();
    write_cfg(REG_UNUSED, 13'h1fff);
    cfg_valid <= 1'b0;

    // random frames under three idling profiles
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 60 : 0;
      recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 30 : 0;
      while (sent < 80 + (ph + 1) * 320) begin
        m = $urandom_range(3);
        if (m == 1 || m == 2) w = 4 * $urandom_range(2, 5);
        else w = $urandom_range(2, 16);
        r = $urandom_range(2, 6);
        set_geometry(w, r, m);
        if (ph == 2 && hold_ack == hold_req && sent < 900) hold_req++;
        run_frame(w, r, 1, 0);
        wait_idle();
      end
    end

    repeat (20) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("** separable_binomial_blur_top: PASSED **");
    else
      $display("** separable_binomial_blur_top: FAILED **");
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/sbb_pkg.sv
hw/rtl/sbb_front.sv
hw/rtl/sbb_queue.sv
hw/rtl/sbb_back.sv
hw/rtl/separable_binomial_blur_top.sv
sim/tb.sv
